>>> sv/dcc_rsm_pkg.sv
// ---------------------------------------------------------------------------
// dcc_rsm_pkg
// shared types and codes of the reactive congestion state machine
// ---------------------------------------------------------------------------
package dcc_rsm_pkg;

  typedef enum logic [1:0] {
    ST_RELAXED     = 2'd0,
    ST_ACTIVE      = 2'd1,
    ST_RESTRICTIVE = 2'd2
  } dcc_state_t;

  // configuration register indexes
  localparam logic [2:0] REG_RAMP_UP_WINDOW   = 3'd0;
  localparam logic [2:0] REG_RAMP_DOWN_WINDOW = 3'd1;
  localparam logic [2:0] REG_RELAXED_TO_ACT   = 3'd2;
  localparam logic [2:0] REG_ACT_TO_RELAXED   = 3'd3;
  localparam logic [2:0] REG_ACT_TO_RESTR     = 3'd4;
  localparam logic [2:0] REG_RESTR_TO_ACT     = 3'd5;

  localparam int WIN_W   = 11;
  localparam int LEVEL_W = 9;
  localparam int COUNT_W = 11;

  localparam logic [WIN_W-1:0]   RST_RAMP_UP_WINDOW   = 11'd1024;
  localparam logic [WIN_W-1:0]   RST_RAMP_DOWN_WINDOW = 11'd1024;
  localparam logic [LEVEL_W-1:0] RST_RELAXED_TO_ACT   = 9'd77;
  localparam logic [LEVEL_W-1:0] RST_ACT_TO_RELAXED   = 9'd38;
  localparam logic [LEVEL_W-1:0] RST_ACT_TO_RESTR     = 9'd154;
  localparam logic [LEVEL_W-1:0] RST_RESTR_TO_ACT     = 9'd128;

  // control travelling with an item from the window stage to the state stage
  typedef struct packed {
    logic valid;
    logic eval;
  } dcc_rsm_ctl_t;

endpackage

>>> sv/dcc_rsm_window.sv
// ---------------------------------------------------------------------------
// dcc_rsm_window
// prefix-sum memory of busy ticks and the two window counts
// ---------------------------------------------------------------------------
module dcc_rsm_window import dcc_rsm_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  logic                                   in_valid,
  output logic                                   in_ready,
  input  logic                                   busy_req,
  input  logic                                   evaluate,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        wu,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        wd,
  input  logic                                   take,
  output dcc_rsm_ctl_t                           ctl,
  output logic [$clog2(MAX_WINDOW+1)-1:0]        bu,
  output logic [$clog2(MAX_WINDOW+1)-1:0]        bd
);

  localparam int AW = $clog2(MAX_WINDOW);
  localparam int CW = $clog2(MAX_WINDOW+1);

  logic [CW-1:0] psum_mem [MAX_WINDOW];

  logic [AW-1:0] write_slot;
  logic [CW-1:0] cum;
  logic [CW-1:0] fill;

  logic          s1_valid;
  logic          s1_eval;
  logic [CW-1:0] s1_cum;
  logic          s1_short_u, s1_short_d;
  logic [CW-1:0] s1_off_u, s1_off_d;
  logic [CW-1:0] rd_u, rd_d;

  logic          accept;
  logic [CW-1:0] cum_next;
  logic [CW:0]   slot_x;
  logic [AW-1:0] addr_u, addr_d;

  assign in_ready = !s1_valid || take;
  assign accept   = in_valid && in_ready;
  assign cum_next = cum + CW'(busy_req);
  assign slot_x   = (CW+1)'(write_slot);

  // slot that held the entry just outside each window
  always_comb begin
    if (slot_x >= {1'b0, wu}) addr_u = AW'(slot_x - {1'b0, wu});
    else                      addr_u = AW'(slot_x + (CW+1)'(MAX_WINDOW) - {1'b0, wu});
    if (slot_x >= {1'b0, wd}) addr_d = AW'(slot_x - {1'b0, wd});
    else                      addr_d = AW'(slot_x + (CW+1)'(MAX_WINDOW) - {1'b0, wd});
  end

  // read-first: a full window reads the old sum of the slot being written
  always_ff @(posedge clk) begin
    if (accept) begin
      psum_mem[write_slot] <= cum_next;
      rd_u <= psum_mem[addr_u];
      rd_d <= psum_mem[addr_d];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      write_slot <= '0;
      cum        <= '0;
      fill       <= '0;
      s1_valid   <= 1'b0;
    end else begin
      if (accept) begin
        write_slot <= (write_slot == AW'(MAX_WINDOW-1)) ? '0 : write_slot + 1'b1;
        cum        <= cum_next;
        if (fill != CW'(MAX_WINDOW)) fill <= fill + 1'b1;
        s1_valid   <= 1'b1;
      end else if (take) begin
        s1_valid   <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s1_eval    <= evaluate;
      s1_cum     <= cum_next;
      s1_short_u <= fill < wu;
      s1_short_d <= fill < wd;
      s1_off_u   <= wu - fill - CW'(1);
      s1_off_d   <= wd - fill - CW'(1);
    end
  end

  // ticks before the first item count as busy
  assign bu = s1_short_u ? s1_cum + s1_off_u : s1_cum - rd_u;
  assign bd = s1_short_d ? s1_cum + s1_off_d : s1_cum - rd_d;

  assign ctl.valid = s1_valid;
  assign ctl.eval  = s1_eval;

endmodule

>>> sv/dcc_rsm_fsm.sv
// ---------------------------------------------------------------------------
// dcc_rsm_fsm
// level checks, three-state controller and result register
// ---------------------------------------------------------------------------
module dcc_rsm_fsm import dcc_rsm_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic                                   clk,
  input  logic                                   rst,
  input  dcc_rsm_ctl_t                           ctl,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        bu,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        bd,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        wu,
  input  logic [$clog2(MAX_WINDOW+1)-1:0]        wd,
  input  logic [LEVEL_W-1:0]                     relaxed_to_active_level,
  input  logic [LEVEL_W-1:0]                     active_to_relaxed_level,
  input  logic [LEVEL_W-1:0]                     active_to_restrictive_level,
  input  logic [LEVEL_W-1:0]                     restrictive_to_active_level,
  output logic                                   take,
  output logic                                   out_valid,
  input  logic                                   out_ready,
  output logic [1:0]                             dcc_state,
  output logic                                   changed,
  output logic [COUNT_W-1:0]                     busy_up_count,
  output logic [COUNT_W-1:0]                     busy_down_count
);

  localparam int CW = $clog2(MAX_WINDOW+1);
  localparam int PW = CW + LEVEL_W;

  logic [PW-1:0] thr_r2a, thr_a2r, thr_a2x, thr_x2a;
  logic [PW-1:0] up_scaled, dn_scaled;
  dcc_state_t    mode_state, mode_state_next;
  logic          changed_next;
  logic [CW+COUNT_W-1:0] bu_ext, bd_ext;

  // thresholds are registered products of the level and window registers
  always_ff @(posedge clk) begin
    thr_r2a <= PW'(relaxed_to_active_level) * PW'(wu);
    thr_a2x <= PW'(active_to_restrictive_level) * PW'(wu);
    thr_a2r <= PW'(active_to_relaxed_level) * PW'(wd);
    thr_x2a <= PW'(restrictive_to_active_level) * PW'(wd);
  end

  assign up_scaled = PW'({bu, 8'd0});
  assign dn_scaled = PW'({bd, 8'd0});
  assign take      = !out_valid || out_ready;

  always_comb begin
    mode_state_next = mode_state;
    if (ctl.eval) begin
      unique case (mode_state)
        ST_ACTIVE: begin
          if (up_scaled >= thr_a2x) mode_state_next = ST_RESTRICTIVE;
          if (dn_scaled <  thr_a2r) mode_state_next = ST_RELAXED;
        end
        ST_RESTRICTIVE: begin
          if (dn_scaled < thr_x2a) mode_state_next = ST_ACTIVE;
        end
        default: begin
          mode_state_next = ST_RELAXED;
          if (up_scaled >= thr_r2a) mode_state_next = ST_ACTIVE;
        end
      endcase
    end
  end

  always_comb begin
    changed_next = (mode_state_next != mode_state);
    bu_ext       = {{COUNT_W{1'b0}}, bu};
    bd_ext       = {{COUNT_W{1'b0}}, bd};
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      mode_state <= ST_RELAXED;
      out_valid  <= 1'b0;
    end else begin
      if (ctl.valid && take) begin
        mode_state <= mode_state_next;
        out_valid  <= 1'b1;
      end else if (out_ready) begin
        out_valid  <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.valid && take) begin
      dcc_state       <= mode_state_next;
      changed         <= changed_next;
      busy_up_count   <= bu_ext[COUNT_W-1:0];
      busy_down_count <= bd_ext[COUNT_W-1:0];
    end
  end

endmodule

>>> sv/dcc_reactive_state_machine_top.sv
// ---------------------------------------------------------------------------
// dcc_reactive_state_machine_top
// reactive three-state channel congestion controller
// ---------------------------------------------------------------------------
// One item per time tick carries the channel-busy bit and an evaluate flag;
// every item yields exactly one result with the state after the tick, a
// changed flag and the busy-tick counts over the ramp-up and ramp-down
// windows (both ending at and including the current tick). The block takes
// one item per clock while the output side keeps up: an item passes the
// window stage register (prefix sum memory written and read), then the
// state check loads the output register; a stall at the output holds the
// item in the window stage. The rate is set by the state update
// and the one write plus two reads of the prefix memory per item. Busy
// counts come from a memory of MAX_WINDOW running sums as the difference
// against the sum stored one window ago; a fill count stands in for the
// all-busy history after reset, so there is no clearing pass. Window
// registers of 0 act as 1 and values above MAX_WINDOW saturate. Write
// configuration only while no item is in flight.
// ---------------------------------------------------------------------------
module dcc_reactive_state_machine_top import dcc_rsm_pkg::*; #(
  parameter int MAX_WINDOW = 1024
) (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic [2:0]         cfg_index,
  input  logic [WIN_W-1:0]   cfg_data,
  input  logic               in_valid,
  output logic               in_ready,
  input  logic               busy_req,
  input  logic               evaluate,
  output logic               out_valid,
  input  logic               out_ready,
  output logic [1:0]         dcc_state,
  output logic               changed,
  output logic [COUNT_W-1:0] busy_up_count,
  output logic [COUNT_W-1:0] busy_down_count
);

  localparam int CW = $clog2(MAX_WINDOW+1);

  // configuration registers
  logic [WIN_W-1:0]   ramp_up_window;
  logic [WIN_W-1:0]   ramp_down_window;
  logic [LEVEL_W-1:0] relaxed_to_active_level;
  logic [LEVEL_W-1:0] active_to_relaxed_level;
  logic [LEVEL_W-1:0] active_to_restrictive_level;
  logic [LEVEL_W-1:0] restrictive_to_active_level;

  // effective window lengths
  logic [CW-1:0] wu, wd;

  logic          take;
  dcc_rsm_ctl_t  ctl;
  logic [CW-1:0] bu, bd;

  always_ff @(posedge clk) begin
    if (rst) begin
      ramp_up_window              <= RST_RAMP_UP_WINDOW;
      ramp_down_window            <= RST_RAMP_DOWN_WINDOW;
      relaxed_to_active_level     <= RST_RELAXED_TO_ACT;
      active_to_relaxed_level     <= RST_ACT_TO_RELAXED;
      active_to_restrictive_level <= RST_ACT_TO_RESTR;
      restrictive_to_active_level <= RST_RESTR_TO_ACT;
    end else if (cfg_we) begin
      // indexes beyond the list are ignored
      unique case (cfg_index)
        REG_RAMP_UP_WINDOW:   ramp_up_window              <= cfg_data;
        REG_RAMP_DOWN_WINDOW: ramp_down_window            <= cfg_data;
        REG_RELAXED_TO_ACT:   relaxed_to_active_level     <= cfg_data[LEVEL_W-1:0];
        REG_ACT_TO_RELAXED:   active_to_relaxed_level     <= cfg_data[LEVEL_W-1:0];
        REG_ACT_TO_RESTR:     active_to_restrictive_level <= cfg_data[LEVEL_W-1:0];
        REG_RESTR_TO_ACT:     restrictive_to_active_level <= cfg_data[LEVEL_W-1:0];
        default: ;
      endcase
    end
  end

  // zero window acts as one tick, oversize saturates
  always_comb begin
    if (ramp_up_window == '0)                          wu = CW'(1);
    else if (32'(ramp_up_window) > 32'(MAX_WINDOW))    wu = CW'(MAX_WINDOW);
    else                                               wu = CW'(ramp_up_window);
    if (ramp_down_window == '0)                        wd = CW'(1);
    else if (32'(ramp_down_window) > 32'(MAX_WINDOW))  wd = CW'(MAX_WINDOW);
    else                                               wd = CW'(ramp_down_window);
  end

  dcc_rsm_window #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_window (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .busy_req (busy_req),
    .evaluate (evaluate),
    .wu       (wu),
    .wd       (wd),
    .take     (take),
    .ctl      (ctl),
    .bu       (bu),
    .bd       (bd)
  );

  dcc_rsm_fsm #(
    .MAX_WINDOW (MAX_WINDOW)
  ) u_fsm (
    .clk                         (clk),
    .rst                         (rst),
    .ctl                         (ctl),
    .bu                          (bu),
    .bd                          (bd),
    .wu                          (wu),
    .wd                          (wd),
    .relaxed_to_active_level     (relaxed_to_active_level),
    .active_to_relaxed_level     (active_to_relaxed_level),
    .active_to_restrictive_level (active_to_restrictive_level),
    .restrictive_to_active_level (restrictive_to_active_level),
    .take                        (take),
    .out_valid                   (out_valid),
    .out_ready                   (out_ready),
    .dcc_state                   (dcc_state),
    .changed                     (changed),
    .busy_up_count               (busy_up_count),
    .busy_down_count             (busy_down_count)
  );

endmodule

>>> sv/dcc_rsm_checker.sv
// ---------------------------------------------------------------------------
// dcc_rsm_checker
// port-level checks on the result stream of the state machine
// ---------------------------------------------------------------------------
module dcc_rsm_checker import dcc_rsm_pkg::*; (
  input logic               clk,
  input logic               rst,
  input logic               out_valid,
  input logic               out_ready,
  input logic [1:0]         dcc_state,
  input logic               changed,
  input logic [COUNT_W-1:0] busy_up_count,
  input logic [COUNT_W-1:0] busy_down_count
);

  // state carried by the last delivered result
  logic [1:0] last_state;

  always_ff @(posedge clk) begin
    if (rst) begin
      last_state <= ST_RELAXED;
    end else if (out_valid && out_ready) begin
      last_state <= dcc_state;
    end
  end

  a_no_valid_after_reset: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("result valid right after reset");

  a_stall_holds: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_ready |=> out_valid && $stable(dcc_state) && $stable(changed)
      && $stable(busy_up_count) && $stable(busy_down_count))
    else $error("stalled result changed");

  a_changed_matches: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> (changed == (dcc_state != last_state)))
    else $error("changed flag disagrees with state sequence");

  a_no_skip: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> !((last_state == ST_RELAXED && dcc_state == ST_RESTRICTIVE)
      || (last_state == ST_RESTRICTIVE && dcc_state == ST_RELAXED)))
    else $error("state skipped active");

endmodule

bind dcc_reactive_state_machine_top dcc_rsm_checker u_checker (
  .clk             (clk),
  .rst             (rst),
  .out_valid       (out_valid),
  .out_ready       (out_ready),
  .dcc_state       (dcc_state),
  .changed         (changed),
  .busy_up_count   (busy_up_count),
  .busy_down_count (busy_down_count)
);

>>> sim/tb_dcc_reactive_state_machine_top.sv
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// tb_dcc_reactive_state_machine_top
// self-checking bench for the reactive three-state congestion controller
// ---------------------------------------------------------------------------
// A short table of directed ticks and register writes runs first, then
// phases of random ticks, most under random window and level settings.
// Every accepted item feeds a local model of the busy history and the
// state machine; each result is compared field by field with the oldest
// prediction. Both handshakes stall at random, apart from one steady phase.
// ---------------------------------------------------------------------------
module tb_dcc_reactive_state_machine_top;
  import dcc_rsm_pkg::*;

  localparam int HIST_DEPTH      = 1024;
  localparam int LIMIT_CYCLES    = 200000;
  localparam int RAND_PHASES     = 6;
  localparam int TICKS_PER_PHASE = 100;
  localparam int STEADY_PHASE    = 2;
  localparam int IDLE_PCT        = 13;
  localparam int TAIL_CYCLES     = 8;

  // register indexes the block does not decode
  localparam logic [2:0] REG_SPARE_LO = 3'd6;
  localparam logic [2:0] REG_SPARE_HI = 3'd7;

  typedef struct packed {
    dcc_state_t         st;
    logic               chg;
    logic [COUNT_W-1:0] up;
    logic [COUNT_W-1:0] dn;
  } tick_result_t;

  // one line of the directed table: either a register write or a tick
  typedef struct {
    logic               is_cfg;
    logic [2:0]         idx;
    logic [WIN_W-1:0]   data;
    logic               busy;
    logic               eval;
    logic               typed;
    tick_result_t       want;
  } stim_row_t;

  logic               clk = 1'b0;
  logic               rst;
  logic               cfg_we;
  logic [2:0]         cfg_index;
  logic [WIN_W-1:0]   cfg_data;
  logic               in_valid;
  logic               in_ready;
  logic               busy_req;
  logic               evaluate;
  logic               out_valid;
  logic               out_ready = 1'b0;
  logic [1:0]         dcc_state;
  logic               changed;
  logic [COUNT_W-1:0] busy_up_count;
  logic [COUNT_W-1:0] busy_down_count;

  // typed expectation travelling with the item on the input side
  logic         row_typed;
  tick_result_t row_want;

  // no idling on either side while set
  logic steady;

  int fault_count = 0;
  int cycle_count = 0;

  tick_result_t awaited_results[$];
  stim_row_t    stim_rows[$];

  // model copy of the block's state and registers
  logic [HIST_DEPTH-1:0] busy_history;
  int                    hist_slot;
  dcc_state_t            mode_now;
  logic [WIN_W-1:0]      win_up, win_dn;
  logic [LEVEL_W-1:0]    lvl_relaxed_to_act, lvl_act_to_relaxed;
  logic [LEVEL_W-1:0]    lvl_act_to_restr, lvl_restr_to_act;

  tick_result_t scored_tick, oldest_tick;

  dcc_reactive_state_machine_top u_dut (
    .clk             (clk),
    .rst             (rst),
    .cfg_we          (cfg_we),
    .cfg_index       (cfg_index),
    .cfg_data        (cfg_data),
    .in_valid        (in_valid),
    .in_ready        (in_ready),
    .busy_req        (busy_req),
    .evaluate        (evaluate),
    .out_valid       (out_valid),
    .out_ready       (out_ready),
    .dcc_state       (dcc_state),
    .changed         (changed),
    .busy_up_count   (busy_up_count),
    .busy_down_count (busy_down_count)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // ---------------------------------------------------------------------
  // model of the channel history and the state machine
  // ---------------------------------------------------------------------

  // zero acts as one tick, anything past the history depth saturates
  function automatic int span_of(input logic [WIN_W-1:0] w);
    if (w == '0) return 1;
    if (int'(w) > HIST_DEPTH) return HIST_DEPTH;
    return int'(w);
  endfunction

  // busy ticks among the newest n entries, the newest sitting before hist_slot
  function automatic int busy_in_span(input int n);
    int total;
    total = 0;
    for (int i = 1; i <= n; i++) begin
      total += busy_history[(hist_slot - i + HIST_DEPTH) % HIST_DEPTH];
    end
    return total;
  endfunction

  function automatic tick_result_t predict_tick(input logic b, input logic e);
    tick_result_t r;
    dcc_state_t   nxt;
    int           wu, wd, bu, bd;
    busy_history[hist_slot] = b;
    hist_slot = (hist_slot + 1) % HIST_DEPTH;
    wu = span_of(win_up);
    wd = span_of(win_dn);
    bu = busy_in_span(wu);
    bd = busy_in_span(wd);
    nxt = mode_now;
    if (e) begin
      case (mode_now)
        ST_ACTIVE: begin
          if (bu * 256 >= int'(lvl_act_to_restr) * wu) nxt = ST_RESTRICTIVE;
          // falling back to relaxed wins when both hold
          if (bd * 256 < int'(lvl_act_to_relaxed) * wd) nxt = ST_RELAXED;
        end
        ST_RESTRICTIVE: begin
          if (bd * 256 < int'(lvl_restr_to_act) * wd) nxt = ST_ACTIVE;
        end
        default: begin
          nxt = ST_RELAXED;
          if (bu * 256 >= int'(lvl_relaxed_to_act) * wu) nxt = ST_ACTIVE;
        end
      endcase
    end
    r.st  = nxt;
    r.chg = (nxt != mode_now);
    r.up  = bu[COUNT_W-1:0];
    r.dn  = bd[COUNT_W-1:0];
    mode_now = nxt;
    return r;
  endfunction

  // ---------------------------------------------------------------------
  // input side prediction and output side checking, one clocked process
  // ---------------------------------------------------------------------
  always @(posedge clk) begin
    if (!rst) begin
      if (in_valid && in_ready) begin
        scored_tick = predict_tick(busy_req, evaluate);
        // typed rows keep the model moving but check against the table
        awaited_results.push_back(row_typed ? row_want : scored_tick);
      end
      if (out_valid && out_ready) begin
        if (awaited_results.size() == 0) begin
          $display("%0t: result with no item waiting: state %0d up %0d down %0d",
                   $time, dcc_state, busy_up_count, busy_down_count);
          fault_count++;
        end else begin
          oldest_tick = awaited_results.pop_front();
          if (dcc_state !== oldest_tick.st) begin
            $display("%0t: dcc_state expected %0d got %0d",
                     $time, oldest_tick.st, dcc_state);
            fault_count++;
          end
          if (changed !== oldest_tick.chg) begin
            $display("%0t: changed expected %0d got %0d",
                     $time, oldest_tick.chg, changed);
            fault_count++;
          end
          if (busy_up_count !== oldest_tick.up) begin
            $display("%0t: busy_up_count expected %0d got %0d",
                     $time, oldest_tick.up, busy_up_count);
            fault_count++;
          end
          if (busy_down_count !== oldest_tick.dn) begin
            $display("%0t: busy_down_count expected %0d got %0d",
                     $time, oldest_tick.dn, busy_down_count);
            fault_count++;
          end
        end
      end
    end
  end

  // receiver stalls at random outside the steady phase
  always @(posedge clk) begin
    out_ready <= steady || ($urandom_range(99) >= IDLE_PCT);
  end

  // watchdog
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count >= LIMIT_CYCLES) begin
      $display("tb_dcc_reactive_state_machine_top: FAIL");
      $finish;
    end
  end

  // ---------------------------------------------------------------------
  // driving tasks
  // ---------------------------------------------------------------------

  // one register write, mirrored into the model straight away
  task automatic program_reg(input logic [2:0] idx, input logic [WIN_W-1:0] data);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= data;
    case (idx)
      REG_RAMP_UP_WINDOW:   win_up = data;
      REG_RAMP_DOWN_WINDOW: win_dn = data;
      REG_RELAXED_TO_ACT:   lvl_relaxed_to_act = data[LEVEL_W-1:0];
      REG_ACT_TO_RELAXED:   lvl_act_to_relaxed = data[LEVEL_W-1:0];
      REG_ACT_TO_RESTR:     lvl_act_to_restr = data[LEVEL_W-1:0];
      REG_RESTR_TO_ACT:     lvl_restr_to_act = data[LEVEL_W-1:0];
      default: ;
    endcase
    @(posedge clk);
  endtask

  // holds the item until accepted; idles first now and then
  task automatic send_tick(input logic b, input logic e, input logic t,
                           input tick_result_t w);
    cfg_we <= 1'b0;
    while (!steady && $urandom_range(99) < IDLE_PCT) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid  <= 1'b1;
    busy_req  <= b;
    evaluate  <= e;
    row_typed <= t;
    row_want  <= w;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
  endtask

  // sender stops until every predicted result has come back
  task automatic drain_results();
    in_valid <= 1'b0;
    @(posedge clk);
    while (awaited_results.size() != 0) @(posedge clk);
  endtask

  // table builders
  task automatic add_cfg(input logic [2:0] idx, input logic [WIN_W-1:0] data);
    stim_row_t r;
    r = '{default: '0};
    r.is_cfg = 1'b1;
    r.idx    = idx;
    r.data   = data;
    stim_rows.push_back(r);
  endtask

  task automatic add_tick(input logic b, input logic e);
    stim_row_t r;
    r = '{default: '0};
    r.busy = b;
    r.eval = e;
    stim_rows.push_back(r);
  endtask

  task automatic add_checked(input logic b, input logic e, input dcc_state_t st,
                             input logic chg, input int up, input int dn);
    stim_row_t r;
    r = '{default: '0};
    r.busy    = b;
    r.eval    = e;
    r.typed   = 1'b1;
    r.want.st  = st;
    r.want.chg = chg;
    r.want.up  = up[COUNT_W-1:0];
    r.want.dn  = dn[COUNT_W-1:0];
    stim_rows.push_back(r);
  endtask

  function automatic logic [WIN_W-1:0] pick_window();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 11'd1024;
      2:       return 11'd2047;
      default: return 11'($urandom_range(1, 48));
    endcase
  endfunction

  function automatic logic [WIN_W-1:0] pick_level();
    case ($urandom_range(9))
      0:       return '0;
      1:       return 11'($urandom_range(257, 2047));
      default: return 11'($urandom_range(0, 256));
    endcase
  endfunction

  // ---------------------------------------------------------------------
  // stimulus
  // ---------------------------------------------------------------------
  initial begin : stimulus
    int        busy_pct;
    logic      last_was_cfg;
    stim_row_t row;

    rst       = 1'b1;
    cfg_we    = 1'b0;
    cfg_index = '0;
    cfg_data  = '0;
    in_valid  = 1'b0;
    busy_req  = 1'b0;
    evaluate  = 1'b0;
    row_typed = 1'b0;
    row_want  = '0;
    steady    = 1'b0;

    // model state after reset: history all busy, relaxed, reset registers
    busy_history       = '1;
    hist_slot          = 0;
    mode_now           = ST_RELAXED;
    win_up             = RST_RAMP_UP_WINDOW;
    win_dn             = RST_RAMP_DOWN_WINDOW;
    lvl_relaxed_to_act = RST_RELAXED_TO_ACT;
    lvl_act_to_relaxed = RST_ACT_TO_RELAXED;
    lvl_act_to_restr   = RST_ACT_TO_RESTR;
    lvl_restr_to_act   = RST_RESTR_TO_ACT;

    // after reset the unwritten history reads as busy
    add_checked(1'b1, 1'b0, ST_RELAXED,     1'b0, 1024, 1024);
    add_checked(1'b0, 1'b1, ST_ACTIVE,      1'b1, 1023, 1023);
    add_checked(1'b1, 1'b1, ST_RESTRICTIVE, 1'b1, 1023, 1023);
    add_checked(1'b0, 1'b1, ST_RESTRICTIVE, 1'b0, 1022, 1022);
    // zero window acts as one tick, oversize window saturates
    add_cfg(REG_RAMP_UP_WINDOW, 11'd0);
    add_cfg(REG_RAMP_DOWN_WINDOW, 11'd2047);
    add_cfg(REG_RESTR_TO_ACT, 11'd256);
    add_tick(1'b0, 1'b1);
    // level zero: the up test always holds, the down test never
    add_cfg(REG_ACT_TO_RELAXED, 11'd0);
    add_cfg(REG_ACT_TO_RESTR, 11'd0);
    add_tick(1'b0, 1'b1);
    add_tick(1'b0, 1'b0);
    add_tick(1'b1, 1'b1);
    // one-tick windows, levels above full scale and one level of zero
    add_cfg(REG_RAMP_DOWN_WINDOW, 11'd1);
    add_cfg(REG_RELAXED_TO_ACT, 11'd511);
    add_cfg(REG_ACT_TO_RELAXED, 11'd257);
    add_cfg(REG_ACT_TO_RESTR, 11'd300);
    add_cfg(REG_RESTR_TO_ACT, 11'd0);
    add_checked(1'b1, 1'b1, ST_RELAXED, 1'b1, 1, 1);
    add_checked(1'b1, 1'b1, ST_RELAXED, 1'b0, 1, 1);
    // full scale level exactly met
    add_cfg(REG_RELAXED_TO_ACT, 11'd256);
    add_checked(1'b1, 1'b1, ST_ACTIVE,  1'b1, 1, 1);
    add_checked(1'b0, 1'b1, ST_RELAXED, 1'b1, 0, 0);
    add_checked(1'b1, 1'b1, ST_ACTIVE,  1'b1, 1, 1);
    add_cfg(REG_ACT_TO_RELAXED, 11'd0);
    add_cfg(REG_ACT_TO_RESTR, 11'd256);
    add_checked(1'b1, 1'b1, ST_RESTRICTIVE, 1'b1, 1, 1);
    add_checked(1'b1, 1'b1, ST_RESTRICTIVE, 1'b0, 1, 1);
    add_cfg(REG_RESTR_TO_ACT, 11'd256);
    add_checked(1'b1, 1'b1, ST_RESTRICTIVE, 1'b0, 1, 1);
    add_checked(1'b0, 1'b1, ST_ACTIVE,      1'b1, 0, 0);
    // undecoded indexes must leave every register alone
    add_cfg(REG_SPARE_LO, 11'd0);
    add_cfg(REG_SPARE_HI, 11'd511);
    add_checked(1'b0, 1'b1, ST_ACTIVE, 1'b0, 0, 0);
    // widen again: counts are exact over the new window from the next tick
    add_cfg(REG_RAMP_UP_WINDOW, 11'd1024);
    add_cfg(REG_RAMP_DOWN_WINDOW, 11'd1025);
    add_tick(1'b1, 1'b0);
    add_tick(1'b0, 1'b1);
    add_tick(1'b1, 1'b1);

    repeat (4) @(posedge clk);
    rst <= 1'b0;

    // directed table
    last_was_cfg = 1'b1;
    foreach (stim_rows[i]) begin
      row = stim_rows[i];
      if (row.is_cfg) begin
        if (!last_was_cfg) drain_results();
        program_reg(row.idx, row.data);
      end else begin
        send_tick(row.busy, row.eval, row.typed, row.want);
      end
      last_was_cfg = row.is_cfg;
    end

    // random phases, each under fresh settings; the last one restores reset
    for (int p = 0; p < RAND_PHASES; p++) begin
      drain_results();
      if (p == RAND_PHASES - 1) begin
        program_reg(REG_RAMP_UP_WINDOW,   RST_RAMP_UP_WINDOW);
        program_reg(REG_RAMP_DOWN_WINDOW, RST_RAMP_DOWN_WINDOW);
        program_reg(REG_RELAXED_TO_ACT,   WIN_W'(RST_RELAXED_TO_ACT));
        program_reg(REG_ACT_TO_RELAXED,   WIN_W'(RST_ACT_TO_RELAXED));
        program_reg(REG_ACT_TO_RESTR,     WIN_W'(RST_ACT_TO_RESTR));
        program_reg(REG_RESTR_TO_ACT,     WIN_W'(RST_RESTR_TO_ACT));
      end else begin
        program_reg(REG_RAMP_UP_WINDOW,   pick_window());
        program_reg(REG_RAMP_DOWN_WINDOW, pick_window());
        program_reg(REG_RELAXED_TO_ACT,   pick_level());
        program_reg(REG_ACT_TO_RELAXED,   pick_level());
        program_reg(REG_ACT_TO_RESTR,     pick_level());
        program_reg(REG_RESTR_TO_ACT,     pick_level());
        if ($urandom_range(1) == 0) program_reg(REG_SPARE_HI, pick_window());
      end
      steady   = (p == STEADY_PHASE);
      busy_pct = $urandom_range(100);
      for (int k = 0; k < TICKS_PER_PHASE; k++) begin
        // load drifts so the busy fraction sweeps across the levels
        if (k % 16 == 15) busy_pct = $urandom_range(100);
        send_tick($urandom_range(99) < busy_pct, $urandom_range(3) != 0,
                  1'b0, '0);
      end
      steady = 1'b0;
    end

    drain_results();
    repeat (TAIL_CYCLES) @(posedge clk);
    if (fault_count == 0) begin
      $display("tb_dcc_reactive_state_machine_top: PASS");
    end else begin
      $display("tb_dcc_reactive_state_machine_top: FAIL");
    end
    $finish;
  end

endmodule
